// File: rtl/cubic_bezier_point_generator_assert.svh
// Assertion macros shared by the cubic Bezier point generator.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_ASSERT_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBPG_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbpg: same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define CBPG_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbpg: next-cycle implication violated");

`endif

// File: rtl/cbpg_pkg.sv
// Shared types and constants for the cubic Bezier point generator.
// Used by the lane, the controller, the datapath, the top level and the testbench. Depends on nothing.
package cbpg_pkg;

	localparam int PT_W      = 63;  // one packed x,y,z point
	localparam int CNT_W     = 7;   // step count field
	localparam int IDX_W     = 6;   // point index field
	localparam int NUM_PTS   = 4;
	localparam int NUM_AXES  = 3;
	localparam int STEP_W    = 3;
	localparam int IN_DATA_W = ((NUM_PTS * PT_W + CNT_W + 7) / 8) * 8;

	// Last step of the weight and multiply-accumulate phases.
	localparam logic [STEP_W-1:0] WGT_LAST = 3'd5;
	localparam logic [STEP_W-1:0] MAC_LAST = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_WGT  = 5'b00100,
		ST_MAC  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	typedef struct packed {
		logic              load;
		logic              div_step;
		logic              wgt_step;
		logic              mac_step;
		logic              emit;
		logic [STEP_W-1:0] step;
	} cbpg_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic last_point;
	} cbpg_status_t;

endpackage

// File: rtl/cbpg_lane.sv
// One coordinate lane: multiply-accumulates four control coordinates by their weights.
// Each weight is taken in two halves, so a point takes eight steps. Uses cbpg_pkg.
module cbpg_lane #(
	parameter int COORD_BITS  = 21,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cbpg_pkg::STEP_W-1:0]   step,
	input  logic signed [COORD_BITS-1:0]  coord  [cbpg_pkg::NUM_PTS],
	input  logic [3*T_FRAC_BITS:0]        weight [cbpg_pkg::NUM_PTS],
	output logic signed [COORD_BITS-1:0]  result
);

	localparam int W_W   = 3 * T_FRAC_BITS + 1;
	localparam int LO_W  = (W_W + 1) / 2;
	localparam int P_W   = COORD_BITS + LO_W + 1;
	localparam int ACC_W = 3 * T_FRAC_BITS + COORD_BITS + 1;
	localparam logic [ACC_W-1:0] ROUND = {{(ACC_W-1){1'b0}}, 1'b1} << (3 * T_FRAC_BITS - 1);

	logic [1:0]              term;
	logic                    hi;
	logic [W_W-1:0]          w_sel;
	logic [LO_W-1:0]         half_w;
	logic signed [P_W-1:0]   c_ext;
	logic signed [P_W-1:0]   w_ext;
	logic signed [P_W-1:0]   prod;
	logic signed [ACC_W-1:0] p_ext;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] acc_q;

	assign term   = step[2:1];
	assign hi     = step[0];
	assign w_sel  = weight[term];
	assign half_w = hi ? LO_W'(w_sel >> LO_W) : w_sel[LO_W-1:0];
	assign c_ext  = P_W'(coord[term]);
	assign w_ext  = P_W'(half_w);
	assign prod   = c_ext * w_ext;
	assign p_ext  = ACC_W'(prod);
	assign addend = hi ? (p_ext <<< LO_W) : p_ext;

	// The first step seeds the accumulator with one half for round-to-nearest.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= ((step == '0) ? $signed(ROUND) : acc_q) + addend;
		end
	end

	assign result = acc_q[3*T_FRAC_BITS +: COORD_BITS];

endmodule

// File: rtl/cbpg_ctrl.sv
// Controller of the cubic Bezier point generator: phase sequencing and output valid.
// Drives cbpg_pkg::cbpg_cmd_t to the datapath and reads cbpg_pkg::cbpg_status_t.
module cbpg_ctrl #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  cbpg_pkg::cbpg_status_t status,
	output cbpg_pkg::cbpg_cmd_t    cmd
);

	localparam int CW = $clog2(T_FRAC_BITS + 2);

	cbpg_pkg::state_t state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.step = cnt_q[cbpg_pkg::STEP_W-1:0];
		unique case (state_q)
			cbpg_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = status.count_zero ? cbpg_pkg::ST_IDLE : cbpg_pkg::ST_DIV;
				end
			end
			cbpg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CW'(T_FRAC_BITS)) begin
					cnt_d   = '0;
					state_d = cbpg_pkg::ST_WGT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbpg_pkg::ST_WGT: begin
				cmd.wgt_step = 1'b1;
				if (cnt_q == CW'(cbpg_pkg::WGT_LAST)) begin
					cnt_d   = '0;
					state_d = cbpg_pkg::ST_MAC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbpg_pkg::ST_MAC: begin
				cmd.mac_step = 1'b1;
				if (cnt_q == CW'(cbpg_pkg::MAC_LAST)) begin
					cnt_d   = '0;
					state_d = cbpg_pkg::ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbpg_pkg::ST_EMIT: begin
				// The result register may only be reloaded once its transaction is done.
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = status.last_point ? cbpg_pkg::ST_IDLE : cbpg_pkg::ST_WGT;
				end
			end
			default: begin
				state_d = cbpg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbpg_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == cbpg_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/cbpg_datapath.sv
// Datapath of the cubic Bezier point generator: count divider, step tracker,
// weight unit, three coordinate lanes and the result register. Uses cbpg_pkg, cbpg_lane.
module cbpg_datapath #(
	parameter int MAX_STEPS   = 64,
	parameter int COORD_BITS  = 21,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  cbpg_pkg::cbpg_cmd_t               cmd,
	input  logic [cbpg_pkg::IN_DATA_W-1:0]    in_data,
	output cbpg_pkg::cbpg_status_t            status,
	output logic signed [COORD_BITS-1:0]      point_x,
	output logic signed [COORD_BITS-1:0]      point_y,
	output logic signed [COORD_BITS-1:0]      point_z,
	output logic [cbpg_pkg::IDX_W-1:0]        point_index,
	output logic                              last_point
);

	localparam int TW   = T_FRAC_BITS + 1;
	localparam int SQ_W = 2 * T_FRAC_BITS + 1;
	localparam int B_W  = T_FRAC_BITS + 2;
	localparam int W_W  = 3 * T_FRAC_BITS + 1;
	localparam int PR_W = SQ_W + B_W;
	localparam int CN   = cbpg_pkg::CNT_W;

	localparam logic [cbpg_pkg::STEP_W-1:0] WS_TT  = 3'd0;
	localparam logic [cbpg_pkg::STEP_W-1:0] WS_UU  = 3'd1;
	localparam logic [cbpg_pkg::STEP_W-1:0] WS_T3  = 3'd2;
	localparam logic [cbpg_pkg::STEP_W-1:0] WS_T2U = 3'd3;
	localparam logic [cbpg_pkg::STEP_W-1:0] WS_TU2 = 3'd4;
	localparam logic [cbpg_pkg::STEP_W-1:0] WS_U3  = 3'd5;

	logic [CN-1:0]   cnt_in, n_sat, n_q;
	logic signed [COORD_BITS-1:0] coord_q [cbpg_pkg::NUM_PTS][cbpg_pkg::NUM_AXES];

	// Restoring divider for 2^T / n: quotient shifts into dvd_q, remainder in rem_q.
	logic [TW-1:0]   dvd_q;
	logic [CN-1:0]   rem_q;
	logic [CN:0]     rem_sh;
	logic            div_ge;

	logic [TW-1:0]   t_q, u, t_next;
	logic [CN-1:0]   r_q, r_next, i_q;
	logic [CN:0]     r_sum;
	logic            r_ge;
	logic [B_W-1:0]  t3, u3;

	logic [SQ_W-1:0] tt_q, uu_q, a_op;
	logic [B_W-1:0]  b_op;
	logic [PR_W-1:0] prod;
	logic [W_W-1:0]  w_q [cbpg_pkg::NUM_PTS];

	logic signed [COORD_BITS-1:0] res [cbpg_pkg::NUM_AXES];

	assign cnt_in = in_data[cbpg_pkg::NUM_PTS*cbpg_pkg::PT_W +: CN];
	assign n_sat  = (int'(cnt_in) > MAX_STEPS) ? CN'(MAX_STEPS) : cnt_in;

	assign rem_sh = {rem_q, dvd_q[TW-1]};
	assign div_ge = (rem_sh >= {1'b0, n_q});

	// t advances by the quotient, plus one when the remainders carry past n.
	assign r_sum  = {1'b0, r_q} + {1'b0, rem_q};
	assign r_ge   = (r_sum >= {1'b0, n_q});
	assign r_next = CN'(r_ge ? (r_sum - {1'b0, n_q}) : r_sum);
	assign t_next = t_q + dvd_q + TW'(r_ge);
	assign u      = (TW'(1) << T_FRAC_BITS) - t_q;
	assign t3     = {t_q, 1'b0} + B_W'(t_q);
	assign u3     = {u, 1'b0} + B_W'(u);

	always_comb begin
		unique case (cmd.step)
			WS_TT: begin
				a_op = SQ_W'(t_q);
				b_op = B_W'(t_q);
			end
			WS_UU: begin
				a_op = SQ_W'(u);
				b_op = B_W'(u);
			end
			WS_T3: begin
				a_op = tt_q;
				b_op = B_W'(t_q);
			end
			WS_T2U: begin
				a_op = tt_q;
				b_op = u3;
			end
			WS_TU2: begin
				a_op = uu_q;
				b_op = t3;
			end
			WS_U3: begin
				a_op = uu_q;
				b_op = B_W'(u);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod = PR_W'(a_op) * PR_W'(b_op);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= n_sat;
			dvd_q <= TW'(1) << T_FRAC_BITS;
			rem_q <= '0;
			t_q   <= '0;
			r_q   <= '0;
			i_q   <= '0;
			for (int j = 0; j < cbpg_pkg::NUM_PTS; j++) begin
				for (int k = 0; k < cbpg_pkg::NUM_AXES; k++) begin
					coord_q[j][k] <= in_data[j*cbpg_pkg::PT_W + k*COORD_BITS +: COORD_BITS];
				end
			end
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[TW-2:0], div_ge};
			rem_q <= CN'(div_ge ? (rem_sh - {1'b0, n_q}) : rem_sh);
		end
		// Weights kept in point order: start, end, start tangent, end tangent.
		if (cmd.wgt_step) begin
			unique case (cmd.step)
				WS_TT:   tt_q   <= prod[SQ_W-1:0];
				WS_UU:   uu_q   <= prod[SQ_W-1:0];
				WS_T3:   w_q[0] <= prod[W_W-1:0];
				WS_T2U:  w_q[2] <= prod[W_W-1:0];
				WS_TU2:  w_q[3] <= prod[W_W-1:0];
				WS_U3:   w_q[1] <= prod[W_W-1:0];
				default: ;
			endcase
		end
		if (cmd.emit) begin
			point_x     <= res[0];
			point_y     <= res[1];
			point_z     <= res[2];
			point_index <= i_q[cbpg_pkg::IDX_W-1:0];
			last_point  <= status.last_point;
			t_q         <= t_next;
			r_q         <= r_next;
			i_q         <= i_q + 1'b1;
		end
	end

	for (genvar k = 0; k < cbpg_pkg::NUM_AXES; k++) begin : g_lane
		logic signed [COORD_BITS-1:0] lane_coord [cbpg_pkg::NUM_PTS];

		for (genvar j = 0; j < cbpg_pkg::NUM_PTS; j++) begin : g_pt
			assign lane_coord[j] = coord_q[j][k];
		end

		cbpg_lane #(
			.COORD_BITS  (COORD_BITS),
			.T_FRAC_BITS (T_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.en     (cmd.mac_step),
			.step   (cmd.step),
			.coord  (lane_coord),
			.weight (w_q),
			.result (res[k])
		);
	end

	assign status.count_zero = (n_sat == '0);
	assign status.last_point = (CN'(i_q + 1'b1) == n_q);

endmodule

// File: rtl/cubic_bezier_point_generator.sv
// Cubic Bezier point generator: takes four 3D points and a count N, and emits N curve
// points at t = i/N. An item is taken only when the block is idle; it first passes
// through a one-bit-per-cycle divider that forms 2^T / N, after which t is stepped
// with an add and compare. Each point then gets its weights from the shared weight
// multiplier, is multiply-accumulated in the three coordinate lanes and moves into
// the output register, waiting while that register still holds a result whose
// transaction is not done. A count of zero emits nothing; counts above MAX_STEPS
// saturate to MAX_STEPS.
// Uses cbpg_pkg, cbpg_ctrl, cbpg_datapath and the assertion macro header.
`include "cubic_bezier_point_generator_assert.svh"

module cubic_bezier_point_generator #(
	parameter int MAX_STEPS   = 64,
	parameter int COORD_BITS  = 21,
	parameter int T_FRAC_BITS = 16,
	localparam int OUT_DATA_W = ((3 * COORD_BITS + cbpg_pkg::IDX_W + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// start_point, end_point, start_tangent, end_tangent, step_count
	input  logic [cbpg_pkg::IN_DATA_W-1:0] s_axis_tdata,

	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// point_x, point_y, point_z, point_index
	output logic [OUT_DATA_W-1:0]          m_axis_tdata,
	output logic                           m_axis_tlast
);

	cbpg_pkg::cbpg_cmd_t    cmd;
	cbpg_pkg::cbpg_status_t status;

	logic signed [COORD_BITS-1:0]  point_x, point_y, point_z;
	logic [cbpg_pkg::IDX_W-1:0]    point_index;
	logic                          last_point;

	cbpg_ctrl #(
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	cbpg_datapath #(
		.MAX_STEPS   (MAX_STEPS),
		.COORD_BITS  (COORD_BITS),
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.in_data     (s_axis_tdata),
		.status      (status),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_index (point_index),
		.last_point  (last_point)
	);

	assign m_axis_tdata = OUT_DATA_W'({point_index, point_z, point_y, point_x});
	assign m_axis_tlast = last_point;

	// A pending result is never overwritten before its transaction.
	`CBPG_ASSERT_IMPL(a_no_overwrite, cmd.emit, !m_axis_tvalid || m_axis_tready)
	// After the final point of a run is handed off, the block takes input again.
	`CBPG_ASSERT_NEXT(a_idle_after_last, cmd.emit && status.last_point, s_axis_tready)
	// An item with a zero count leaves the block idle.
	`CBPG_ASSERT_NEXT(a_zero_count_idle, s_axis_tvalid && s_axis_tready && status.count_zero,
		s_axis_tready)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for cubic_bezier_point_generator: directed and random curve requests,
// with the expected curve points computed in 128-bit fixed point and matched in arrival order.
// Depends on cbpg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_STEPS    = 64;
	localparam int COORD_BITS   = 21;
	localparam int T_FRAC_BITS  = 16;
	localparam int OUT_DATA_W   = 72;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 1000;
	localparam int HOLD_CYCLES  = 400;
	localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (3 * T_FRAC_BITS - 1);

	typedef logic [cbpg_pkg::PT_W-1:0]      point3_t;
	typedef logic [cbpg_pkg::IN_DATA_W-1:0] request_t;

	typedef struct {
		logic [COORD_BITS-1:0]      x;
		logic [COORD_BITS-1:0]      y;
		logic [COORD_BITS-1:0]      z;
		logic [cbpg_pkg::IDX_W-1:0] idx;
		logic                       last;
	} curve_point_t;

	class bezier_scoreboard;
		curve_point_t expected_points[$];
		int unsigned  mismatches;
		int unsigned  points_checked;

		function new();
			mismatches     = 0;
			points_checked = 0;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		// Evaluates the curve of one accepted request at t = i/N for every step i.
		function void note_item(request_t req);
			point3_t               pts[cbpg_pkg::NUM_PTS];
			int                    n;
			int                    t;
			logic signed [COORD_BITS-1:0] c;
			logic signed [127:0]   ctl[cbpg_pkg::NUM_PTS];
			logic signed [127:0]   tw;
			logic signed [127:0]   uw;
			logic signed [127:0]   acc;
			logic signed [127:0]   axis_val[cbpg_pkg::NUM_AXES];
			curve_point_t          p;
			for (int k = 0; k < cbpg_pkg::NUM_PTS; k++)
				pts[k] = req[k*cbpg_pkg::PT_W +: cbpg_pkg::PT_W];
			n = int'(req[cbpg_pkg::NUM_PTS*cbpg_pkg::PT_W +: cbpg_pkg::CNT_W]);
			if (n > MAX_STEPS)
				n = MAX_STEPS;
			for (int i = 0; i < n; i++) begin
				t  = (i << T_FRAC_BITS) / n;
				tw = 128'(t);
				uw = 128'((1 << T_FRAC_BITS) - t);
				for (int a = 0; a < cbpg_pkg::NUM_AXES; a++) begin
					for (int k = 0; k < cbpg_pkg::NUM_PTS; k++) begin
						c      = pts[k][a*COORD_BITS +: COORD_BITS];
						ctl[k] = 128'(c);
					end
					// Order of the latched points: start, end, start tangent, end tangent.
					acc = ctl[0] * tw * tw * tw
						+ 3 * ctl[2] * tw * tw * uw
						+ 3 * ctl[3] * tw * uw * uw
						+ ctl[1] * uw * uw * uw
						+ ROUND_HALF;
					axis_val[a] = acc >>> (3 * T_FRAC_BITS);
				end
				p.x    = axis_val[0][COORD_BITS-1:0];
				p.y    = axis_val[1][COORD_BITS-1:0];
				p.z    = axis_val[2][COORD_BITS-1:0];
				p.idx  = i[cbpg_pkg::IDX_W-1:0];
				p.last = (i == n - 1);
				expected_points.insert(expected_points.size(), p);
			end
		endfunction

		function void check_point(logic [OUT_DATA_W-1:0] data, logic last);
			curve_point_t got;
			curve_point_t exp_p;
			got.x    = data[0 +: COORD_BITS];
			got.y    = data[COORD_BITS +: COORD_BITS];
			got.z    = data[2*COORD_BITS +: COORD_BITS];
			got.idx  = data[3*COORD_BITS +: cbpg_pkg::IDX_W];
			got.last = last;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected point x=%h y=%h z=%h index=%0d last=%b",
						got.x, got.y, got.z, got.idx, got.last);
				return;
			end
			exp_p = expected_points.pop_front();
			points_checked++;
			if (got.x !== exp_p.x || got.y !== exp_p.y || got.z !== exp_p.z ||
					got.idx !== exp_p.idx || got.last !== exp_p.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("tb: point mismatch at %0t", $realtime);
					$display("    expected x=%h y=%h z=%h index=%0d last=%b",
						exp_p.x, exp_p.y, exp_p.z, exp_p.idx, exp_p.last);
					$display("    actual   x=%h y=%h z=%h index=%0d last=%b",
						got.x, got.y, got.z, got.idx, got.last);
				end
			end
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	request_t              s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	bezier_scoreboard sb = new();

	int tx_idle_max = 11;
	int rx_idle_max = 11;
	bit hold_req    = 1'b0;
	int idle_cycles = 0;
	int items_sent  = 0;
	int zero_items  = 0;
	int clamped_items = 0;

	cubic_bezier_point_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic logic [COORD_BITS-1:0] rand_coord(int mode);
		case (mode)
			0: rand_coord = COORD_BITS'($urandom);
			1: rand_coord = COORD_BITS'($urandom_range(0, 31) - 16);
			default: rand_coord = $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
		endcase
	endfunction

	function automatic point3_t rand_point(int mode);
		return {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
	endfunction

	function automatic request_t pack_item(point3_t sp, point3_t ep, point3_t st, point3_t et,
			logic [cbpg_pkg::CNT_W-1:0] n);
		request_t r;
		r = '0;
		r[0*cbpg_pkg::PT_W +: cbpg_pkg::PT_W] = sp;
		r[1*cbpg_pkg::PT_W +: cbpg_pkg::PT_W] = ep;
		r[2*cbpg_pkg::PT_W +: cbpg_pkg::PT_W] = st;
		r[3*cbpg_pkg::PT_W +: cbpg_pkg::PT_W] = et;
		r[cbpg_pkg::NUM_PTS*cbpg_pkg::PT_W +: cbpg_pkg::CNT_W] = n;
		return r;
	endfunction

	// Valid is lowered only when a gap follows, so it never toggles within one step.
	task automatic send_item(request_t req);
		int gap;
		int n;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(req);
		n = int'(req[cbpg_pkg::NUM_PTS*cbpg_pkg::PT_W +: cbpg_pkg::CNT_W]);
		items_sent++;
		if (n == 0)
			zero_items++;
		if (n > MAX_STEPS)
			clamped_items++;
	endtask

	task automatic send_random_item();
		int sel;
		int n;
		int mode;
		point3_t p[cbpg_pkg::NUM_PTS];
		sel = $urandom_range(0, 99);
		if (sel < 8)
			n = 0;
		else if (sel < 88)
			n = $urandom_range(1, 12);
		else if (sel < 96)
			n = $urandom_range(13, 64);
		else
			n = $urandom_range(65, 127);
		for (int k = 0; k < cbpg_pkg::NUM_PTS; k++) begin
			mode = $urandom_range(0, 9);
			p[k] = rand_point(mode < 6 ? 0 : (mode < 8 ? 1 : 2));
		end
		send_item(pack_item(p[0], p[1], p[2], p[3], cbpg_pkg::CNT_W'(n)));
	endtask

	// Receiver: random stalls before each point, plus one long hold-off on request.
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = $urandom_range(0, rx_idle_max);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid && !hold_req);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_point(m_axis_tdata, m_axis_tlast);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: watchdog expired, %0d points still expected", sb.pending());
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int rx_plan[8] = '{11, 0, 11, 0, 5, 11, 2, 11};
		int tx_plan[8] = '{11, 0, 0, 11, 3, 11, 11, 0};
		point3_t pmax;
		point3_t pmin;
		pmax = {3{21'h0FFFFF}};
		pmin = {3{21'h100000}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: count extremes, saturation and coordinate extremes.
		send_item(pack_item(rand_point(0), rand_point(0), rand_point(0), rand_point(0), 7'd0));
		send_item(pack_item(rand_point(0), rand_point(0), rand_point(0), rand_point(0), 7'd1));
		send_item(pack_item(pmax, pmax, pmax, pmax, 7'd2));
		send_item(pack_item(pmin, pmin, pmin, pmin, 7'd3));
		send_item(pack_item(rand_point(0), rand_point(0), rand_point(0), rand_point(0), 7'd64));
		send_item(pack_item(rand_point(0), rand_point(0), rand_point(0), rand_point(0), 7'd65));
		send_item(pack_item(rand_point(1), rand_point(1), rand_point(1), rand_point(1), 7'd127));
		send_item(pack_item(rand_point(2), rand_point(2), rand_point(2), rand_point(2), 7'd63));
		send_item(pack_item(pmax, pmin, pmax, pmin, 7'd7));
		send_item(pack_item(pmin, pmax, pmin, pmax, 7'd6));
		send_item(pack_item('0, '0, '0, '0, 7'd3));
		send_item(pack_item('1, '1, '1, '1, 7'd0));
		send_item(pack_item('1, '1, '1, '1, 7'd5));
		send_item(pack_item({21'h155555, 21'h0AAAAA, 21'h155555},
			{21'h0AAAAA, 21'h155555, 21'h0AAAAA}, '1, '0, 7'd4));
		send_item(pack_item(rand_point(1), rand_point(1), rand_point(1), rand_point(1), 7'd3));

		for (int ph = 0; ph < 8; ph++) begin
			tx_idle_max = tx_plan[ph];
			rx_idle_max = rx_plan[ph];
			// Phase 3 runs with a long receiver hold-off so the block backs up into its input.
			if (ph == 3)
				hold_req = 1'b1;
			repeat (50) send_random_item();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests sent, %0d with count zero, %0d above the step maximum",
			items_sent, zero_items, clamped_items);
		$display("tb: %0d curve points checked, %0d mismatches", sb.points_checked,
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
